// ===== src/bvg_pkg.sv =====
// shared types and constants of the battery voltage gauge
package bvg_pkg;

  // quotient bits produced by the percent divider
  localparam int QUO_W = 16;
  // divisor width, covers 2*(full_mv-empty_mv)
  localparam int DIV_W = 17;
  // dividend width, numerator must stay below divisor * 2^QUO_W
  localparam int NUM_W = DIV_W + QUO_W;

  localparam int MV_W  = 16;
  localparam int PCT_W = 7;
  localparam int NF_W  = 10;
  localparam int IN_W  = 12;

  // percent numerator is (v - empty) * 200 + span
  localparam int PCT_MUL_W = 24;
  localparam logic [7:0] PCT_SCALE = 8'd200;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EMPTY      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL       = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE      = 2'd3;

  localparam logic [MV_W-1:0] RST_FULL_SCALE = 16'd6600;
  localparam logic [MV_W-1:0] RST_EMPTY      = 16'd3300;
  localparam logic [MV_W-1:0] RST_FULL       = 16'd4200;
  localparam logic [NF_W-1:0] RST_NOISE      = 10'd20;

  typedef struct packed {
    logic cap_in;
    logic mul_scale;
    logic fold_step;
    logic div_start;
    logic store_mv;
    logic mul_pct;
    logic load_out;
  } bvg_cmd_t;

  typedef struct packed {
    logic fold_done;
    logic div_done;
    logic inverted;
    logic out_free;
  } bvg_stat_t;

endpackage

// ===== src/bvg_div.sv =====
// restoring divider, one quotient bit per cycle
module bvg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bvg_pkg::NUM_W-1:0]  num,
  input  logic [bvg_pkg::DIV_W-1:0]  den,
  output logic                       done,
  output logic [bvg_pkg::QUO_W-1:0]  quo
);

  localparam int CNT_W = $clog2(bvg_pkg::QUO_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [bvg_pkg::DIV_W-1:0] rem;
  logic [bvg_pkg::DIV_W-1:0] den_q;
  logic [bvg_pkg::DIV_W:0]   shifted;
  logic                      ge;
  logic [bvg_pkg::DIV_W:0]   diff;

  assign shifted = {rem, quo[bvg_pkg::QUO_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(bvg_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // high dividend bits are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[bvg_pkg::NUM_W-1:bvg_pkg::QUO_W];
      quo   <= num[bvg_pkg::QUO_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[bvg_pkg::DIV_W-1:0] : shifted[bvg_pkg::DIV_W-1:0];
      quo <= {quo[bvg_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ===== src/bvg_datapath.sv =====
// gauge datapath: config registers, scaling, trend ring, percent and result register
module bvg_datapath #(
  parameter int TREND_DEPTH = 4,
  parameter int ADC_BITS    = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bvg_pkg::bvg_cmd_t               cmd,
  output bvg_pkg::bvg_stat_t              stat,
  input  logic                            cfg_valid,
  input  logic [bvg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]                     cfg_data,
  input  logic [bvg_pkg::IN_W-1:0]        sample_in,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata
);

  localparam int SLOT_W = $clog2(TREND_DEPTH);
  localparam int FILL_W = $clog2(TREND_DEPTH + 1);
  localparam logic [15:0] TOP = 16'((1 << ADC_BITS) - 1);

  logic [bvg_pkg::MV_W-1:0] full_scale_mv;
  logic [bvg_pkg::MV_W-1:0] empty_mv;
  logic [bvg_pkg::MV_W-1:0] full_mv;
  logic [bvg_pkg::NF_W-1:0] noise_floor_mv;

  logic [15:0]                   sample;
  logic [31:0]                   scale_rem;
  logic [bvg_pkg::MV_W-1:0]      scale_quo;
  logic [bvg_pkg::MV_W-1:0]      scale_mv;
  logic [bvg_pkg::PCT_MUL_W-1:0] pct_prod;
  logic [bvg_pkg::MV_W-1:0]      span;
  logic [bvg_pkg::MV_W-1:0]      mv;
  logic                          charging;

  logic [bvg_pkg::MV_W-1:0] ring [TREND_DEPTH];
  logic [SLOT_W-1:0]        write_slot;
  logic [FILL_W-1:0]        fill_count;

  logic [bvg_pkg::NUM_W-1:0] div_num;
  logic [bvg_pkg::DIV_W-1:0] div_den;
  logic                      div_done;
  logic [bvg_pkg::QUO_W-1:0] quo;

  logic [SLOT_W-1:0]        slot_next;
  logic [FILL_W-1:0]        fill_next;
  logic [SLOT_W-1:0]        oldest_idx;
  logic [bvg_pkg::MV_W:0]   newest_sum;
  logic [bvg_pkg::MV_W-1:0] clamped;
  logic [bvg_pkg::MV_W-1:0] above;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv  <= bvg_pkg::RST_FULL_SCALE;
      empty_mv       <= bvg_pkg::RST_EMPTY;
      full_mv        <= bvg_pkg::RST_FULL;
      noise_floor_mv <= bvg_pkg::RST_NOISE;
    end else if (cfg_valid) begin
      case (cfg_addr)
        bvg_pkg::REG_FULL_SCALE: full_scale_mv  <= cfg_data;
        bvg_pkg::REG_EMPTY:      empty_mv       <= cfg_data;
        bvg_pkg::REG_FULL:       full_mv        <= cfg_data;
        bvg_pkg::REG_NOISE:      noise_floor_mv <= cfg_data[bvg_pkg::NF_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.inverted  = full_mv <= empty_mv;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.fold_done = (scale_rem >> ADC_BITS) == '0;

  // percent operands: clamp to the empty..full window
  always_comb begin
    if (mv < empty_mv) begin
      clamped = empty_mv;
    end else if (mv > full_mv) begin
      clamped = full_mv;
    end else begin
      clamped = mv;
    end
    above = clamped - empty_mv;
  end

  // division by 2^ADC_BITS - 1: the high part is added to the quotient and folded
  // back onto the low part until the remainder fits in ADC_BITS bits
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      sample <= 16'(sample_in) & TOP;
    end
    if (cmd.mul_scale) begin
      scale_rem <= sample * full_scale_mv;
      scale_quo <= '0;
    end else if (cmd.fold_step) begin
      scale_quo <= scale_quo + bvg_pkg::MV_W'(scale_rem >> ADC_BITS);
      scale_rem <= (scale_rem >> ADC_BITS) + (scale_rem & {16'b0, TOP});
    end
    if (cmd.mul_pct) begin
      pct_prod <= bvg_pkg::PCT_MUL_W'(above) * bvg_pkg::PCT_MUL_W'(bvg_pkg::PCT_SCALE);
      span     <= full_mv - empty_mv;
    end
  end

  // remainder top bit rounds half up, a remainder of all ones counts as one more
  assign scale_mv = scale_quo + bvg_pkg::MV_W'(scale_rem[ADC_BITS-1]);

  assign div_num = bvg_pkg::NUM_W'(pct_prod) + bvg_pkg::NUM_W'(span);
  assign div_den = {span, 1'b0};

  bvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // ring bookkeeping; once two values are stored, the oldest slot is never the one being written
  always_comb begin
    slot_next  = (write_slot == SLOT_W'(TREND_DEPTH - 1)) ? '0 : write_slot + 1'b1;
    fill_next  = (fill_count < FILL_W'(TREND_DEPTH)) ? fill_count + 1'b1 : fill_count;
    oldest_idx = (fill_next < FILL_W'(TREND_DEPTH)) ? '0 : slot_next;
    newest_sum = {1'b0, scale_mv} + (bvg_pkg::MV_W + 1)'(noise_floor_mv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (cmd.store_mv) begin
      write_slot <= slot_next;
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_mv) begin
      ring[write_slot] <= scale_mv;
      mv               <= scale_mv;
      charging         <= (fill_next >= FILL_W'(2)) &&
                          (newest_sum > {1'b0, ring[oldest_idx]});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {charging,
                  stat.inverted ? {bvg_pkg::PCT_W{1'b0}} : quo[bvg_pkg::PCT_W-1:0],
                  mv};
    end
  end

endmodule

// ===== src/bvg_ctrl.sv =====
// gauge sequencer: steps one sample through scaling, store and percent
module bvg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  bvg_pkg::bvg_stat_t  stat,
  output bvg_pkg::bvg_cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCALE_MUL,
    SCALE_FOLD,
    PCT_MUL,
    PCT_DIV,
    PCT_WAIT,
    EMIT
  } state_t;

  state_t state;

  assign s_tready = state == IDLE;

  always_comb begin
    cmd           = '0;
    cmd.cap_in    = (state == IDLE) && s_tvalid;
    cmd.mul_scale = state == SCALE_MUL;
    cmd.fold_step = (state == SCALE_FOLD) && !stat.fold_done;
    cmd.div_start = state == PCT_DIV;
    cmd.store_mv  = (state == SCALE_FOLD) && stat.fold_done;
    cmd.mul_pct   = state == PCT_MUL;
    cmd.load_out  = (state == EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= SCALE_MUL;
          end
        end
        SCALE_MUL: state <= SCALE_FOLD;
        SCALE_FOLD: begin
          if (stat.fold_done) begin
            state <= PCT_MUL;
          end
        end
        PCT_MUL: begin
          // inverted levels give zero percent, no division needed
          state <= stat.inverted ? EMIT : PCT_DIV;
        end
        PCT_DIV: state <= PCT_WAIT;
        PCT_WAIT: begin
          if (stat.div_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/battery_voltage_gauge_trend.sv =====
// battery voltage gauge top level: scaled millivolts, charge percent and charging trend
// flow: capture, millivolt multiply, up to three fold steps of the 12-bit millivolt scaling,
// then percent multiply and division, the division skipped when full_mv <= empty_mv
// throughput: one sample at a time, next request taken on the cycle after the result is loaded;
// the result register lets a new sample start while the previous result waits
// reset: synchronous, clears registers to their defaults, ring write slot and fill count to zero
module battery_voltage_gauge_trend #(
  parameter int TREND_DEPTH = 4,
  parameter int ADC_BITS    = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // [11:0] adc_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [15:0] battery_mv, [22:16] charge_percent,
                                                     // [23] charging
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bvg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]                     cfg_data
);

  bvg_pkg::bvg_cmd_t  cmd;
  bvg_pkg::bvg_stat_t stat;

  assign cfg_ready = 1'b1;

  bvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bvg_datapath #(
    .TREND_DEPTH (TREND_DEPTH),
    .ADC_BITS    (ADC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .sample_in (s_tdata[bvg_pkg::IN_W-1:0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench of the battery voltage gauge: directed table, then randomized phases
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 4;
  localparam int SAMPLE_MAX = (1 << bvg_pkg::IN_W) - 1;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    logic [bvg_pkg::MV_W-1:0]  mv;
    logic [bvg_pkg::PCT_W-1:0] pct;
    logic                      charging;
  } reading_t;

  typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [bvg_pkg::CFG_ADDR_W-1:0] addr;
    logic [15:0]                    value;
    logic [bvg_pkg::IN_W-1:0]       sample;
    bit                             typed;   // mv and pct typed in, charging always predicted
    logic [bvg_pkg::MV_W-1:0]       want_mv;
    logic [bvg_pkg::PCT_W-1:0]      want_pct;
  } drill_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [15:0]                    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [23:0]                    m_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bvg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [15:0]                    cfg_data = '0;

  battery_voltage_gauge_trend DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // predictor copy of the registers and the voltage history
  int unsigned gauge_full_scale = 32'(bvg_pkg::RST_FULL_SCALE);
  int unsigned gauge_empty = 32'(bvg_pkg::RST_EMPTY);
  int unsigned gauge_full = 32'(bvg_pkg::RST_FULL);
  int unsigned gauge_noise = 32'(bvg_pkg::RST_NOISE);
  int unsigned history_mv [RING_DEPTH];
  int unsigned history_slot = 0;
  int unsigned history_fill = 0;

  reading_t   pending_readings [$];
  drill_row_t drill [$];
  int errors = 0;
  int n_samples = 0;
  int n_readings = 0;
  int n_writes = 0;
  bit burst_mode = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("%0t timeout with %0d readings outstanding", $time, pending_readings.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic void apply_register(logic [bvg_pkg::CFG_ADDR_W-1:0] addr,
                                         logic [15:0] value);
    case (addr)
      bvg_pkg::REG_FULL_SCALE: gauge_full_scale = 32'(value);
      bvg_pkg::REG_EMPTY:      gauge_empty = 32'(value);
      bvg_pkg::REG_FULL:       gauge_full = 32'(value);
      bvg_pkg::REG_NOISE:      gauge_noise = 32'(value[bvg_pkg::NF_W-1:0]);
      default: ;
    endcase
  endfunction

  // scale to millivolts, store in the history, then derive percent and trend
  function automatic reading_t predict_reading(logic [bvg_pkg::IN_W-1:0] sample);
    reading_t r;
    longint unsigned num;
    longint unsigned v;
    longint unsigned span;
    int unsigned newest;
    int unsigned oldest;
    num = 2 * longint'(sample) * longint'(gauge_full_scale) + SAMPLE_MAX;
    r.mv = bvg_pkg::MV_W'(num / (2 * SAMPLE_MAX));
    history_mv[history_slot] = 32'(r.mv);
    history_slot = (history_slot + 1) % RING_DEPTH;
    if (history_fill < RING_DEPTH) history_fill++;
    if (gauge_full <= gauge_empty) begin
      r.pct = '0;
    end else begin
      v = 64'(r.mv);
      if (v < gauge_empty) v = 64'(gauge_empty);
      if (v > gauge_full) v = 64'(gauge_full);
      span = 64'(gauge_full - gauge_empty);
      r.pct = bvg_pkg::PCT_W'(((v - gauge_empty) * 200 + span) / (2 * span));
    end
    if (history_fill < 2) begin
      r.charging = 1'b0;
    end else begin
      newest = (history_slot + RING_DEPTH - 1) % RING_DEPTH;
      oldest = (history_fill < RING_DEPTH) ? 0 : history_slot;
      r.charging = (history_mv[newest] + gauge_noise > history_mv[oldest]);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (burst_mode || r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  task automatic send_sample(logic [bvg_pkg::IN_W-1:0] sample, bit typed,
                             logic [bvg_pkg::MV_W-1:0] want_mv,
                             logic [bvg_pkg::PCT_W-1:0] want_pct);
    int gap;
    reading_t r;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {{(16 - bvg_pkg::IN_W){1'b0}}, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_reading(sample);
    if (typed) begin
      r.mv = want_mv;
      r.pct = want_pct;
    end
    pending_readings.push_back(r);
    n_samples++;
  endtask

  // every sample gives a reading, so an empty queue means the block is idle
  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [bvg_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(addr, value);
    n_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic add_sample(logic [bvg_pkg::IN_W-1:0] sample);
    drill.push_back('{ROW_SAMPLE, '0, '0, sample, 1'b0, '0, '0});
  endtask

  task automatic add_typed(logic [bvg_pkg::IN_W-1:0] sample, logic [bvg_pkg::MV_W-1:0] mv,
                           logic [bvg_pkg::PCT_W-1:0] pct);
    drill.push_back('{ROW_SAMPLE, '0, '0, sample, 1'b1, mv, pct});
  endtask

  task automatic add_write(logic [bvg_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] value);
    drill.push_back('{ROW_WRITE, addr, value, '0, 1'b0, '0, '0});
  endtask

  task automatic pick_settings();
    logic [15:0] e;
    case ($urandom_range(0, 5))
      0: begin
        write_register(bvg_pkg::REG_FULL_SCALE, 16'($urandom_range(6000, 7000)));
        write_register(bvg_pkg::REG_EMPTY, 16'($urandom_range(3000, 3500)));
        write_register(bvg_pkg::REG_FULL, 16'($urandom_range(3900, 4400)));
        write_register(bvg_pkg::REG_NOISE, 16'($urandom_range(0, 60)));
      end
      1: begin
        write_register(bvg_pkg::REG_FULL_SCALE, 16'($urandom));
        write_register(bvg_pkg::REG_EMPTY, 16'($urandom));
        write_register(bvg_pkg::REG_FULL, 16'($urandom));
        write_register(bvg_pkg::REG_NOISE, 16'($urandom));
      end
      2: begin
        write_register(bvg_pkg::REG_FULL_SCALE, 16'hFFFF);
        write_register(bvg_pkg::REG_EMPTY, 16'h0000);
        write_register(bvg_pkg::REG_FULL, 16'hFFFF);
        write_register(bvg_pkg::REG_NOISE, 16'h03FF);
      end
      3: begin
        // inverted or equal levels
        e = 16'($urandom);
        write_register(bvg_pkg::REG_FULL_SCALE, 16'($urandom));
        write_register(bvg_pkg::REG_EMPTY, e);
        write_register(bvg_pkg::REG_FULL, 16'($urandom_range(0, e)));
        write_register(bvg_pkg::REG_NOISE, 16'($urandom_range(0, 1023)));
      end
      4: begin
        write_register(bvg_pkg::REG_FULL_SCALE, 16'($urandom_range(0, 20)));
        write_register(bvg_pkg::REG_EMPTY, 16'h0000);
        write_register(bvg_pkg::REG_FULL, 16'($urandom_range(1, 20)));
        write_register(bvg_pkg::REG_NOISE, 16'h0000);
      end
      default: begin
        write_register(bvg_pkg::REG_FULL_SCALE, bvg_pkg::RST_FULL_SCALE);
        write_register(bvg_pkg::REG_EMPTY, bvg_pkg::RST_EMPTY);
        write_register(bvg_pkg::REG_FULL, bvg_pkg::RST_FULL);
        write_register(bvg_pkg::REG_NOISE, {6'b0, bvg_pkg::RST_NOISE});
      end
    endcase
  endtask

  // result side: random stalls, mostly short, now and then long
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 60)) @(negedge clk);
      m_tready <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 100)) @(negedge clk);
      else repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    reading_t w;
    if (!rst && m_tvalid && m_tready) begin
      n_readings++;
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected reading %h", $time, m_tdata);
        errors++;
      end else begin
        w = pending_readings.pop_front();
        if (m_tdata[15:0] !== w.mv) begin
          $display("%0t battery_mv expected %0d actual %0d", $time, w.mv, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[22:16] !== w.pct) begin
          $display("%0t charge_percent expected %0d actual %0d", $time, w.pct, m_tdata[22:16]);
          errors++;
        end
        if (m_tdata[23] !== w.charging) begin
          $display("%0t charging expected %0d actual %0d", $time, w.charging, m_tdata[23]);
          errors++;
        end
      end
    end
  end

  initial begin
    int walk;
    int r;
    logic [bvg_pkg::IN_W-1:0] sample;

    // reset-state readings
    add_typed(12'd0, 16'd0, 7'd0);
    add_typed(12'hFFF, 16'd6600, 7'd100);
    add_sample(12'hAAA);
    add_sample(12'h555);
    add_sample(12'hFFF);
    add_sample(12'd1);
    add_sample(12'd2048);
    // noise floor above its width, and at zero for a flat trend
    add_write(bvg_pkg::REG_NOISE, 16'hFFFF);
    add_sample(12'd0);
    add_sample(12'hFFF);
    add_write(bvg_pkg::REG_NOISE, 16'h0000);
    add_sample(12'hFFF);
    add_sample(12'hFFF);
    add_sample(12'hFFE);
    // equal and inverted levels
    add_write(bvg_pkg::REG_FULL, 16'd3300);
    add_typed(12'd2048, 16'd3301, 7'd0);
    add_write(bvg_pkg::REG_FULL, 16'd1000);
    add_typed(12'hFFF, 16'd6600, 7'd0);
    add_write(bvg_pkg::REG_FULL_SCALE, 16'd0);
    add_typed(12'hFFF, 16'd0, 7'd0);
    // widest scale and span
    add_write(bvg_pkg::REG_FULL_SCALE, 16'hFFFF);
    add_write(bvg_pkg::REG_EMPTY, 16'h0000);
    add_write(bvg_pkg::REG_FULL, 16'hFFFF);
    add_typed(12'hFFF, 16'hFFFF, 7'd100);
    add_typed(12'd0, 16'd0, 7'd0);
    add_sample(12'd2048);
    add_write(bvg_pkg::REG_EMPTY, 16'hFFFF);
    add_write(bvg_pkg::REG_FULL, 16'h0000);
    add_typed(12'hFFF, 16'hFFFF, 7'd0);
    add_write(bvg_pkg::REG_FULL_SCALE, bvg_pkg::RST_FULL_SCALE);
    add_write(bvg_pkg::REG_EMPTY, bvg_pkg::RST_EMPTY);
    add_write(bvg_pkg::REG_FULL, bvg_pkg::RST_FULL);
    add_write(bvg_pkg::REG_NOISE, {6'b0, bvg_pkg::RST_NOISE});

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (drill[i]) begin
      if (drill[i].kind == ROW_WRITE) begin
        drain();
        write_register(drill[i].addr, drill[i].value);
      end else begin
        send_sample(drill[i].sample, drill[i].typed, drill[i].want_mv, drill[i].want_pct);
      end
    end

    walk = 2048;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      pick_settings();
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = int'($urandom_range(0, 99));
        if (r < 55) begin
          // slow drift, so the trend flag sees both small rises and small drops
          walk = walk + int'($urandom_range(0, 80)) - 40;
          if (walk < 0) walk = 0;
          if (walk > SAMPLE_MAX) walk = SAMPLE_MAX;
          sample = bvg_pkg::IN_W'(walk);
        end else if (r < 85) begin
          sample = bvg_pkg::IN_W'($urandom);
        end else if (r < 92) begin
          sample = ($urandom_range(0, 1) != 0) ? bvg_pkg::IN_W'(SAMPLE_MAX) : '0;
        end else begin
          sample = bvg_pkg::IN_W'(walk);
        end
        send_sample(sample, 1'b0, '0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $display("%0t %0d readings never arrived", $time, pending_readings.size());
      errors++;
    end
    $display("%0d samples sent, %0d readings checked, %0d register writes", n_samples,
             n_readings, n_writes);
    $display("covered scale extremes, equal and inverted levels, noise floor range, ring wrap");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== battery_voltage_gauge_trend.f =====
src/bvg_pkg.sv
src/bvg_div.sv
src/bvg_datapath.sv
src/bvg_ctrl.sv
src/battery_voltage_gauge_trend.sv
bench/tb_top.sv
